// File: rtl/seagle_pkg.sv
package seagle_pkg;

   localparam int unsigned PixelWidth = 32;

   localparam logic [PixelWidth-1:0] MaskHalf = 32'h00FE_FEFE;
   localparam logic [PixelWidth-1:0] MaskHalfLow = 32'h0001_0101;
   localparam logic [PixelWidth-1:0] MaskQuarter = 32'h00FC_FCFC;
   localparam logic [PixelWidth-1:0] MaskQuarterLow = 32'h0003_0303;

   typedef logic [PixelWidth-1:0] pixel_type;

   typedef struct packed {
      pixel_type above_mid;
      pixel_type above_right;
      pixel_type left_px;
      pixel_type centre_px;
      pixel_type right_px;
      pixel_type right_far;
      pixel_type below_left;
      pixel_type below_mid;
      pixel_type below_right;
      pixel_type below_right_far;
      pixel_type low_mid;
      pixel_type low_right;
   } window_type;

   typedef struct packed {
      pixel_type top_left;
      pixel_type top_right;
      pixel_type bottom_left;
      pixel_type bottom_right;
   } block_type;

   function automatic pixel_type half_blend(input pixel_type a, input pixel_type b);
      half_blend = ((a & MaskHalf) >> 1) + ((b & MaskHalf) >> 1) + (a & b & MaskHalfLow);
   endfunction

   // three parts a, one part m
   function automatic pixel_type quarter_blend(input pixel_type a, input pixel_type m);
      pixel_type hi;
      pixel_type lo;
      hi = ((a & MaskQuarter) >> 2) + ((a & MaskQuarter) >> 2)
         + ((a & MaskQuarter) >> 2) + ((m & MaskQuarter) >> 2);
      lo = (a & MaskQuarterLow) + (a & MaskQuarterLow)
         + (a & MaskQuarterLow) + (m & MaskQuarterLow);
      quarter_blend = hi + ((lo >> 2) & MaskQuarterLow);
   endfunction

   function automatic logic differs(input pixel_type a, input pixel_type p,
                                    input pixel_type q);
      differs = (a != p) || (a != q);
   endfunction

endpackage

// File: rtl/super_eagle_scaler.sv
// channel  | ports               | handshake
// ---------+---------------------+--------------------------------------
// request  | req_* (12 pixels)   | word taken when start high, busy low
// response | rsp_out_* (4 pixels)| rsp_strobe high for one cycle
//
// one word accepted every cycle; busy stays low
// response strobes after the word passes the input register and then the output register
// synchronous reset clears the valid flags only; data registers are not reset
// the receiver cannot stall, so nothing is held back
module super_eagle_scaler (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  seagle_pkg::pixel_type req_above_mid,
   input  seagle_pkg::pixel_type req_above_right,
   input  seagle_pkg::pixel_type req_left_px,
   input  seagle_pkg::pixel_type req_centre_px,
   input  seagle_pkg::pixel_type req_right_px,
   input  seagle_pkg::pixel_type req_right_far,
   input  seagle_pkg::pixel_type req_below_left,
   input  seagle_pkg::pixel_type req_below_mid,
   input  seagle_pkg::pixel_type req_below_right,
   input  seagle_pkg::pixel_type req_below_right_far,
   input  seagle_pkg::pixel_type req_low_mid,
   input  seagle_pkg::pixel_type req_low_right,
   output logic                  rsp_strobe,
   output seagle_pkg::pixel_type rsp_out_top_left,
   output seagle_pkg::pixel_type rsp_out_top_right,
   output seagle_pkg::pixel_type rsp_out_bottom_left,
   output seagle_pkg::pixel_type rsp_out_bottom_right
);

   seagle_pkg::window_type win_ff, win_in;
   seagle_pkg::block_type  blk_ff, blk_in;
   logic                   win_valid_ff, win_valid_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   assign busy = 1'b0;

   assign win_valid_in = start && !busy;
   assign rsp_strobe_in = win_valid_ff;

   always_comb begin
      win_in.above_mid = req_above_mid;
      win_in.above_right = req_above_right;
      win_in.left_px = req_left_px;
      win_in.centre_px = req_centre_px;
      win_in.right_px = req_right_px;
      win_in.right_far = req_right_far;
      win_in.below_left = req_below_left;
      win_in.below_mid = req_below_mid;
      win_in.below_right = req_below_right;
      win_in.below_right_far = req_below_right_far;
      win_in.low_mid = req_low_mid;
      win_in.low_right = req_low_right;
   end

   seagle_kernel u_kernel (
      .win(win_ff),
      .blk(blk_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         win_valid_ff <= win_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (win_valid_in) begin
         win_ff <= win_in;
      end
      if (rsp_strobe_in) begin
         blk_ff <= blk_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_out_top_left = blk_ff.top_left;
   assign rsp_out_top_right = blk_ff.top_right;
   assign rsp_out_bottom_left = blk_ff.bottom_left;
   assign rsp_out_bottom_right = blk_ff.bottom_right;

   a_strobe_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 2))
      else $error("response without an accepted word");

   a_word_gets_strobe: assert property (@(posedge clock)
      $past(start, 2) && !$past(reset, 2) && !$past(reset, 1) |-> rsp_strobe)
      else $error("accepted word produced no response");

   a_diag_copy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(req_centre_px, 2) == $past(req_below_right, 2)
      && $past(req_right_px, 2) != $past(req_below_mid, 2)
      |-> rsp_out_top_left == $past(req_centre_px, 2))
      else $error("centre diagonal case did not copy the centre pixel");

endmodule

// File: rtl/seagle_kernel.sv
module seagle_kernel (
   input  seagle_pkg::window_type win,
   output seagle_pkg::block_type  blk
);

   seagle_pkg::pixel_type c, r, d, e;
   seagle_pkg::pixel_type h_cr, h_de, h_dr, h_ce;
   seagle_pkg::pixel_type h_dc, h_dedge, h_cright, h_cd;
   logic eq_ce, eq_dr;
   logic [2:0] cnt_r, cnt_c;

   assign c = win.centre_px;
   assign r = win.right_px;
   assign d = win.below_mid;
   assign e = win.below_right;

   assign eq_ce = (c == e);
   assign eq_dr = (d == r);

   assign h_cr = seagle_pkg::half_blend(c, r);
   assign h_de = seagle_pkg::half_blend(d, e);
   assign h_dr = seagle_pkg::half_blend(d, r);
   assign h_ce = seagle_pkg::half_blend(c, e);
   assign h_dc = seagle_pkg::half_blend(d, seagle_pkg::half_blend(d, c));
   assign h_dedge = seagle_pkg::half_blend(d, h_de);
   assign h_cright = seagle_pkg::half_blend(c, h_cr);
   assign h_cd = seagle_pkg::half_blend(c, seagle_pkg::half_blend(c, d));

   // neighbour-pair vote as two counts
   always_comb begin
      cnt_r = 3'(seagle_pkg::differs(r, win.below_left, win.low_mid))
            + 3'(seagle_pkg::differs(r, win.left_px, win.above_mid))
            + 3'(seagle_pkg::differs(r, win.low_right, win.below_right_far))
            + 3'(seagle_pkg::differs(r, win.above_right, win.right_far));
      cnt_c = 3'(seagle_pkg::differs(c, win.below_left, win.low_mid))
            + 3'(seagle_pkg::differs(c, win.left_px, win.above_mid))
            + 3'(seagle_pkg::differs(c, win.low_right, win.below_right_far))
            + 3'(seagle_pkg::differs(c, win.above_right, win.right_far));
   end

   always_comb begin
      case ({eq_ce, eq_dr})
         2'b01: begin
            blk.top_right = d;
            blk.bottom_left = d;
            blk.top_left = (win.below_left == d || r == win.above_right) ? h_dc : h_cr;
            blk.bottom_right = (r == win.right_far || d == win.low_mid) ? h_dedge : h_de;
         end
         2'b10: begin
            blk.top_left = c;
            blk.bottom_right = c;
            blk.top_right = (win.above_mid == c || e == win.below_right_far) ? h_cright : h_cr;
            blk.bottom_left = (e == win.low_right || win.left_px == c) ? h_cd : h_de;
         end
         2'b11: begin
            if (cnt_r > cnt_c) begin
               blk.top_right = d;
               blk.bottom_left = d;
               blk.top_left = h_cr;
               blk.bottom_right = h_cr;
            end else if (cnt_r < cnt_c) begin
               blk.top_left = c;
               blk.bottom_right = c;
               blk.top_right = h_cr;
               blk.bottom_left = h_cr;
            end else begin
               blk.top_left = c;
               blk.bottom_right = c;
               blk.top_right = d;
               blk.bottom_left = d;
            end
         end
         default: begin
            blk.top_left = seagle_pkg::quarter_blend(c, h_dr);
            blk.bottom_right = seagle_pkg::quarter_blend(e, h_dr);
            blk.top_right = seagle_pkg::quarter_blend(r, h_ce);
            blk.bottom_left = seagle_pkg::quarter_blend(d, h_ce);
         end
      endcase
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import seagle_pkg::*;

   typedef enum int {DIAG_RD, DIAG_CE, DIAG_BOTH, DIAG_NONE} diag_case_e;

   typedef struct {
      window_type win;
      bit         has_known;
      block_type  known;
   } stim_row_t;

   localparam int QUIET_LIMIT = 1000;

   localparam pixel_type PA    = 32'h0012_3456;
   localparam pixel_type PB    = 32'h00AB_CDEF;
   localparam pixel_type PC    = 32'h0080_4020;
   localparam pixel_type PX    = 32'h0099_0011;
   localparam pixel_type PZ    = 32'h0055_AA33;
   localparam pixel_type PA_HI = 32'hFF12_3456;
   localparam pixel_type PB_HI = 32'hFFAB_CDEF;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   window_type req_win = '0;
   logic       rsp_strobe;
   pixel_type  rsp_tl, rsp_tr, rsp_bl, rsp_br;

   bit         typed_valid = 1'b0;
   block_type  typed_block = '0;

   block_type  pending_blocks [$];
   stim_row_t  stim_table [$];
   int         words_sent = 0;
   int         blocks_checked = 0;
   int         errors = 0;
   int         quiet_cycles = 0;
   int         diag_seen [4] = '{0, 0, 0, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   super_eagle_scaler dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_above_mid        (req_win.above_mid),
      .req_above_right      (req_win.above_right),
      .req_left_px          (req_win.left_px),
      .req_centre_px        (req_win.centre_px),
      .req_right_px         (req_win.right_px),
      .req_right_far        (req_win.right_far),
      .req_below_left       (req_win.below_left),
      .req_below_mid        (req_win.below_mid),
      .req_below_right      (req_win.below_right),
      .req_below_right_far  (req_win.below_right_far),
      .req_low_mid          (req_win.low_mid),
      .req_low_right        (req_win.low_right),
      .rsp_strobe           (rsp_strobe),
      .rsp_out_top_left     (rsp_tl),
      .rsp_out_top_right    (rsp_tr),
      .rsp_out_bottom_left  (rsp_bl),
      .rsp_out_bottom_right (rsp_br)
   );

   function automatic pixel_type avg2(input pixel_type a, input pixel_type b);
      return ((a & MaskHalf) >> 1) + ((b & MaskHalf) >> 1) + (a & b & MaskHalfLow);
   endfunction

   function automatic pixel_type avg4(input pixel_type a, input pixel_type b,
                                      input pixel_type c, input pixel_type d);
      pixel_type hi;
      pixel_type lo;
      hi = ((a & MaskQuarter) >> 2) + ((b & MaskQuarter) >> 2)
         + ((c & MaskQuarter) >> 2) + ((d & MaskQuarter) >> 2);
      lo = (a & MaskQuarterLow) + (b & MaskQuarterLow)
         + (c & MaskQuarterLow) + (d & MaskQuarterLow);
      return hi + ((lo >> 2) & MaskQuarterLow);
   endfunction

   function automatic int pair_score(input pixel_type a, input pixel_type b,
                                     input pixel_type p, input pixel_type q);
      int x;
      int y;
      x = (a != p || a != q) ? 1 : 0;
      y = (b != p || b != q) ? 1 : 0;
      return x - y;
   endfunction

   function automatic diag_case_e classify(input window_type w);
      if (w.below_mid == w.right_px && w.centre_px != w.below_right)
         return DIAG_RD;
      else if (w.centre_px == w.below_right && w.below_mid != w.right_px)
         return DIAG_CE;
      else if (w.centre_px == w.below_right)
         return DIAG_BOTH;
      else
         return DIAG_NONE;
   endfunction

   function automatic block_type predict_block(input window_type w);
      block_type b;
      pixel_type c, r, d, e, m1, m2;
      int score;
      c = w.centre_px;
      r = w.right_px;
      d = w.below_mid;
      e = w.below_right;
      case (classify(w))
         DIAG_RD: begin
            b.top_right = d;
            b.bottom_left = d;
            b.top_left = (w.below_left == d || r == w.above_right) ?
                         avg2(d, avg2(d, c)) : avg2(c, r);
            b.bottom_right = (r == w.right_far || d == w.low_mid) ?
                             avg2(d, avg2(d, e)) : avg2(d, e);
         end
         DIAG_CE: begin
            b.top_left = c;
            b.bottom_right = c;
            b.top_right = (w.above_mid == c || e == w.below_right_far) ?
                          avg2(c, avg2(c, r)) : avg2(c, r);
            b.bottom_left = (e == w.low_right || w.left_px == c) ?
                            avg2(c, avg2(c, d)) : avg2(d, e);
         end
         DIAG_BOTH: begin
            score = pair_score(r, c, w.below_left, w.low_mid)
                  + pair_score(r, c, w.left_px, w.above_mid)
                  + pair_score(r, c, w.low_right, w.below_right_far)
                  + pair_score(r, c, w.above_right, w.right_far);
            if (score > 0) begin
               b.top_right = d;
               b.bottom_left = d;
               b.top_left = avg2(c, r);
               b.bottom_right = avg2(c, r);
            end else if (score < 0) begin
               b.top_left = c;
               b.bottom_right = c;
               b.top_right = avg2(c, r);
               b.bottom_left = avg2(c, r);
            end else begin
               b.top_left = c;
               b.bottom_right = c;
               b.top_right = d;
               b.bottom_left = d;
            end
         end
         default: begin
            m1 = avg2(d, r);
            m2 = avg2(c, e);
            b.top_left = avg4(c, c, c, m1);
            b.bottom_right = avg4(e, e, e, m1);
            b.top_right = avg4(r, r, r, m2);
            b.bottom_left = avg4(d, d, d, m2);
         end
      endcase
      return b;
   endfunction

   function automatic pixel_type pick(input pixel_type pal [4]);
      if ($urandom_range(9, 0) < 8)
         return pal[$urandom_range(3, 0)];
      else
         return $urandom();
   endfunction

   function automatic pixel_type flip_bit(input pixel_type p);
      return p ^ (32'h1 << $urandom_range(31, 0));
   endfunction

   // mostly windows built from a small palette so that equalities occur
   function automatic window_type rand_window();
      pixel_type pal [4];
      pixel_type tmp;
      window_type w;
      pal[0] = $urandom();
      for (int k = 1; k < 4; k++) begin
         tmp = $urandom();
         pal[k] = ($urandom_range(3, 0) == 0) ? {tmp[31:24], pal[0][23:0]} : tmp;
      end
      if ($urandom_range(99, 0) < 15) begin
         w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      end else begin
         w.above_mid = pick(pal);
         w.above_right = pick(pal);
         w.left_px = pick(pal);
         w.centre_px = pick(pal);
         w.right_px = pick(pal);
         w.right_far = pick(pal);
         w.below_left = pick(pal);
         w.below_mid = pick(pal);
         w.below_right = pick(pal);
         w.below_right_far = pick(pal);
         w.low_mid = pick(pal);
         w.low_right = pick(pal);
         case (diag_case_e'($urandom_range(3, 0)))
            DIAG_RD: begin
               w.below_mid = w.right_px;
               if (w.below_right == w.centre_px) w.below_right = flip_bit(w.below_right);
            end
            DIAG_CE: begin
               w.below_right = w.centre_px;
               if (w.below_mid == w.right_px) w.below_mid = flip_bit(w.below_mid);
            end
            DIAG_BOTH: begin
               w.below_mid = w.right_px;
               w.below_right = w.centre_px;
            end
            default: begin
               if (w.below_right == w.centre_px) w.below_right = flip_bit(w.below_right);
               if (w.below_mid == w.right_px) w.below_mid = flip_bit(w.below_mid);
            end
         endcase
      end
      return w;
   endfunction

   task automatic add_row(input window_type w, input bit has_known, input block_type known);
      stim_row_t row;
      row.win = w;
      row.has_known = has_known;
      row.known = known;
      stim_table.push_back(row);
   endtask

   task automatic send_word(input window_type w, input bit has_known,
                            input block_type known, input int idle_pct);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_win <= w;
      typed_valid <= has_known;
      typed_block <= known;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   // acceptance, checking and watchdog
   always @(posedge clock) begin
      block_type got;
      block_type want;
      bit taken;
      if (!reset) begin
         taken = start && busy === 1'b0;
         if (taken) begin
            diag_seen[classify(req_win)]++;
            pending_blocks.push_back(typed_valid ? typed_block : predict_block(req_win));
            words_sent++;
         end
         if (rsp_strobe === 1'b1) begin
            got = {rsp_tl, rsp_tr, rsp_bl, rsp_br};
            if (pending_blocks.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result block %h", got);
            end else begin
               want = pending_blocks.pop_front();
               blocks_checked++;
               for (int k = 0; k < 4; k++) begin
                  if (got[(3-k)*32 +: 32] !== want[(3-k)*32 +: 32]) begin
                     errors++;
                     if (errors <= 10)
                        $display("block %0d pixel %0d: expected %h got %h", blocks_checked,
                                 k, want[(3-k)*32 +: 32], got[(3-k)*32 +: 32]);
                  end
               end
            end
         end
         if (taken || rsp_strobe === 1'b1)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no traffic for %0d cycles, %0d blocks outstanding", QUIET_LIMIT,
                     pending_blocks.size());
            $display("tb_top failed");
            $finish;
         end
      end
   end

   initial begin
      int idle_pct [3] = '{0, 73, 10};
      int count [3] = '{140, 130, 130};
      int random_words;

      // uniform windows, zero vote copies keep the top byte
      add_row({12{32'h0}}, 1'b1, {4{32'h0}});
      add_row({12{32'hFFFF_FFFF}}, 1'b1, {4{32'hFFFF_FFFF}});
      add_row({PZ, PZ, PZ, 32'hAA12_3456, 32'h5500_CDEF, PZ, PZ, 32'h5500_CDEF,
               32'hAA12_3456, PZ, PZ, PZ}, 1'b1,
              {32'hAA12_3456, 32'h5500_CDEF, 32'h5500_CDEF, 32'hAA12_3456});
      // neither diagonal, full channels
      add_row({32'h0, 32'h0, 32'h0, 32'h01FF_FFFF, 32'h03FF_FFFF, 32'h0, 32'h0,
               32'h04FF_FFFF, 32'h02FF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1, {4{32'h00FF_FFFF}});
      // r = d
      add_row({PZ, PZ, PZ, PA, PB, PB, PB, PB, PC, PZ, PZ, PZ}, 1'b0, '0);
      add_row({PZ, PB, PZ, PA, PB, PZ, PZ, PB, PC, PZ, PB, PZ}, 1'b0, '0);
      add_row({PZ, PZ, PZ, PA, PB, PZ, PZ, PB, PC, PZ, PZ, PZ}, 1'b0, '0);
      add_row({PZ, PZ, PZ, PA, PB, PZ, PB_HI, PB, PC, PZ, PZ, PZ}, 1'b0, '0);
      // c = e
      add_row({PA, PZ, PZ, PA, PB, PZ, PZ, PC, PA, PZ, PZ, PA}, 1'b0, '0);
      add_row({PZ, PZ, PA, PA, PB, PZ, PZ, PC, PA, PA, PZ, PZ}, 1'b0, '0);
      add_row({PZ, PZ, PZ, PA, PB, PZ, PZ, PC, PA, PZ, PZ, PZ}, 1'b0, '0);
      add_row({PZ, PZ, PZ, PA_HI, PB_HI, PZ, PZ, PC, PA_HI, PZ, PZ, PZ}, 1'b0, '0);
      // both diagonals: positive, negative, balanced and single votes
      add_row({PA, PA, PA, PA, PB, PA, PA, PB, PA, PA, PA, PA}, 1'b0, '0);
      add_row({PB, PB, PB, PA, PB, PB, PB, PB, PA, PB, PB, PB}, 1'b0, '0);
      add_row({PB, PA, PB, PA, PB, PB, PA, PB, PA, PZ, PA, PZ}, 1'b0, '0);
      add_row({PZ, PZ, PZ, PA, PB, PZ, PA, PB, PA, PZ, PA, PZ}, 1'b0, '0);
      // diagonals differing only in the top byte
      add_row({PZ, PZ, PZ, 32'h0112_3456, PB, PZ, PZ, PB, 32'h0212_3456, PZ, PZ, PZ},
              1'b0, '0);
      add_row({PZ, PZ, PZ, PA, 32'h01AB_CDEF, PZ, PZ, 32'h02AB_CDEF, PA, PZ, PZ, PZ},
              1'b0, '0);
      // neither diagonal, blends with carries
      add_row({32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0001_0101,
               32'h8080_8080, 32'h0, 32'h0, 32'h0}, 1'b0, '0);
      add_row({PZ, PX, PZ, PA, PB, PX, PZ, PC, PX, PZ, PX, PZ}, 1'b0, '0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i])
         send_word(stim_table[i].win, stim_table[i].has_known, stim_table[i].known, 0);

      random_words = 0;
      for (int ph = 0; ph < 3; ph++) begin
         for (int n = 0; n < count[ph]; n++) begin
            send_word(rand_window(), 1'b0, '0, idle_pct[ph]);
            random_words++;
         end
      end
      start <= 1'b0;

      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d directed and %0d random words over three pacing phases, %0d blocks checked",
               stim_table.size(), random_words, blocks_checked);
      $display("diagonal cases seen: r=d %0d, c=e %0d, both %0d, neither %0d",
               diag_seen[DIAG_RD], diag_seen[DIAG_CE], diag_seen[DIAG_BOTH],
               diag_seen[DIAG_NONE]);
      if (errors == 0 && pending_blocks.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

// File: super_eagle_scaler.f
rtl/seagle_pkg.sv
rtl/seagle_kernel.sv
rtl/super_eagle_scaler.sv
tb/tb_top.sv
